FILE: design/fbhd_pkg.sv
// ----------------------------------------------------------------------------
// fbhd_pkg
// shared types, constants and arithmetic for the fire burn / diffusion block
// ----------------------------------------------------------------------------
package fbhd_pkg;

   // configuration port
   localparam int PADDR_W   = 3;
   localparam int PDATA_W   = 32;
   localparam int REG_IDX_W = 1;
   localparam int CFG_W     = 11;

   localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
   localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

   localparam logic [CFG_W-1:0] RESET_FRAME_WIDTH  = 11'd1024;
   localparam logic [CFG_W-1:0] RESET_FRAME_HEIGHT = 11'd1024;

   // frame geometry limits
   localparam int MIN_WIDTH  = 3;
   localparam int MIN_HEIGHT = 2;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // burn rule
   localparam logic [7:0] IGNITE_HEAT   = 8'd50;
   localparam logic [7:0] HOT_MID       = 8'd100;
   localparam logic [7:0] HOT_HIGH      = 8'd200;
   localparam logic [7:0] HEAT_CAP      = 8'd250;
   localparam logic [7:0] HEAT_GAIN     = 8'd2;
   localparam logic [7:0] FUEL_DEC_HIGH = 8'd4;
   localparam logic [7:0] FUEL_DEC_MID  = 8'd2;
   localparam logic [7:0] FUEL_DEC_LOW  = 8'd1;

   // diffusion: weighted sum fits 12 bits, divide by 11 as multiply + shift
   localparam int          SUM_W       = 12;
   localparam int          PROD_W      = 24;
   localparam logic [11:0] UP_WEIGHT   = 12'd2;
   localparam logic [11:0] DOWN_WEIGHT = 12'd6;
   localparam logic [23:0] DIV11_MUL   = 24'd2979;
   localparam int          DIV11_SHIFT = 15;

   typedef struct packed {
      logic [7:0] cell_heat;
      logic [7:0] cell_fuel;
   } req_type;

   typedef struct packed {
      logic [7:0] new_heat;
      logic [7:0] new_fuel;
      logic       burnt_out;
      logic       last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [7:0] heat;
      logic [7:0] fuel;
      logic       burnt;
   } cell_type;

   // what the back has to do for one item
   typedef struct packed {
      logic emit_upper;   // emit the cell one row up
      logic diff_upper;   // that cell takes diffusion
      logic emit_prev;    // last row: emit the cell to the left
      logic diff_prev;    // that cell takes diffusion
      logic emit_last;    // last cell of the frame: emit itself
   } flags_type;

   function automatic cell_type burn_cell(input logic [7:0] heat,
                                          input logic [7:0] fuel,
                                          input logic       inner);
      cell_type   burned;
      logic [7:0] dec;
      burned.heat  = heat;
      burned.fuel  = fuel;
      burned.burnt = 1'b0;
      if (heat > HOT_HIGH) begin
         dec = FUEL_DEC_HIGH;
      end else if (heat > HOT_MID) begin
         dec = FUEL_DEC_MID;
      end else begin
         dec = FUEL_DEC_LOW;
      end
      if (inner) begin
         if (fuel != 8'd0) begin
            if (heat > IGNITE_HEAT) begin
               if (fuel <= dec) begin
                  burned.heat  = 8'd0;
                  burned.fuel  = 8'd0;
                  burned.burnt = 1'b1;
               end else begin
                  burned.fuel = fuel - dec;
                  if (heat < HEAT_CAP) begin
                     burned.heat = heat + HEAT_GAIN;
                  end
               end
            end
         end else if (heat != 8'd0) begin
            burned.heat = heat - 8'd1;
         end
      end
      return burned;
   endfunction

   function automatic logic [7:0] diffuse(input logic [7:0] self_h,
                                          input logic [7:0] left_h,
                                          input logic [7:0] right_h,
                                          input logic [7:0] up_h,
                                          input logic [7:0] down_h);
      logic [SUM_W-1:0]  sum;
      logic [PROD_W-1:0] prod;
      logic [7:0]        quot;
      sum  = SUM_W'(self_h) + SUM_W'(left_h) + SUM_W'(right_h)
           + UP_WEIGHT * SUM_W'(up_h) + DOWN_WEIGHT * SUM_W'(down_h);
      prod = PROD_W'(sum) * DIV11_MUL;
      quot = 8'(prod >> DIV11_SHIFT);
      return (quot < self_h) ? self_h : quot;
   endfunction

endpackage

FILE: design/fire_burn_and_heat_diffusion.sv
// ----------------------------------------------------------------------------
// fire_burn_and_heat_diffusion
// Streams grid cells (heat, fuel) in raster order and applies one fire frame
// update: the burn rule on inner columns, then diffusion of each cell with its
// neighbors from the second row on. Results come out one row behind the input:
// a cell of row y releases the matching cell of row y-1, and on the last row
// each cell also releases its left neighbor, the last cell of the frame itself
// as well, so those transactions carry two or three results; last_of_run marks
// the final result of each input. An input transaction is taken every cycle as
// long as the output keeps up; on the last row the output register sends one
// result per cycle, so an input there after the first column holds the back for
// each of its results in turn. Two row memories of MAX_WIDTH entries (burn
// values of the pending row, final heat of the row above) hold the only state
// between rows; they need no clearing after reset since every entry is written
// before its first use in a frame. frame_width (byte address 0) and
// frame_height (address 4) are clamped to 3..MAX_WIDTH and 2..MAX_HEIGHT;
// writing either one restarts the frame at row 0, column 0, and must only
// happen with no results pending.
// ----------------------------------------------------------------------------
module fire_burn_and_heat_diffusion
   import fbhd_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic               clock,
   input  logic               reset,
   // input cell channel
   input  logic               req_valid,
   output logic               req_stall,
   input  req_type            req_data,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_data,
   // configuration port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready
);

   localparam int XW      = $clog2(MAX_WIDTH);
   localparam int ENTRY_W = $bits(flags_type) + $bits(cell_type) + 3 * XW;

   // configuration registers
   logic [CFG_W-1:0]     frame_width_ff, frame_width_in;
   logic [CFG_W-1:0]     frame_height_ff, frame_height_in;
   logic [REG_IDX_W-1:0] reg_sel;
   logic                 csr_write;

   // front side of the queue
   logic                 q_push, q_full;
   cell_type             f_cell;
   flags_type            f_flags;
   logic [XW-1:0]        f_col, f_pend_addr, f_upper_addr;
   logic [ENTRY_W-1:0]   push_entry;

   // back side of the queue
   logic                 q_pop, q_head_valid;
   logic [ENTRY_W-1:0]   head_entry;
   cell_type             h_cell;
   flags_type            h_flags;
   logic [XW-1:0]        h_col, h_pend_addr, h_upper_addr;

   // ------------------------------------------------------------------------
   // register file: writes complete in the access phase, no wait states
   // ------------------------------------------------------------------------
   assign pready    = 1'b1;
   assign reg_sel   = paddr[PADDR_W-1 -: REG_IDX_W];
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_write) begin
         unique case (reg_sel)
            REG_FRAME_WIDTH:  frame_width_in  = pwdata[CFG_W-1:0];
            REG_FRAME_HEIGHT: frame_height_in = pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= RESET_FRAME_WIDTH;
         frame_height_ff <= RESET_FRAME_HEIGHT;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_FRAME_WIDTH:  prdata = PDATA_W'(frame_width_ff);
         REG_FRAME_HEIGHT: prdata = PDATA_W'(frame_height_ff);
         default:          prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------------
   // front: raster position, burn rule, per-cell work tags
   // any register write restarts the frame
   // ------------------------------------------------------------------------
   fbhd_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .restart         (csr_write),
      .frame_width     (frame_width_ff),
      .frame_height    (frame_height_ff),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .queue_full      (q_full),
      .push            (q_push),
      .push_cell       (f_cell),
      .push_flags      (f_flags),
      .push_col        (f_col),
      .push_pend_addr  (f_pend_addr),
      .push_upper_addr (f_upper_addr)
   );

   // ------------------------------------------------------------------------
   // queue: lets the front keep taking cells while the back drains a
   // multi-result transaction or the output is stalled
   // ------------------------------------------------------------------------
   assign push_entry = {f_flags, f_cell, f_col, f_pend_addr, f_upper_addr};

   fbhd_queue #(
      .DATA_W (ENTRY_W),
      .DEPTH  (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (push_entry),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_head_valid),
      .head_data  (head_entry)
   );

   assign {h_flags, h_cell, h_col, h_pend_addr, h_upper_addr} = head_entry;

   // ------------------------------------------------------------------------
   // back: row memories, diffusion, one result per cycle (unless the output stalls) into the output reg
   // ------------------------------------------------------------------------
   fbhd_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (q_head_valid),
      .head_cell       (h_cell),
      .head_flags      (h_flags),
      .head_col        (h_col),
      .head_pend_addr  (h_pend_addr),
      .head_upper_addr (h_upper_addr),
      .pop             (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data)
   );

   // ------------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------------

   // back never retires a transaction the queue does not hold
   a_pop_needs_entry : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_head_valid)
      else $error("back popped an empty queue");

   // an accepted cell is in the queue on the next cycle
   a_accept_queued : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> q_head_valid)
      else $error("accepted transaction missing from queue");

   // a result only appears when the back had work at hand
   a_result_has_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(q_head_valid))
      else $error("result produced without a queued transaction");

endmodule

FILE: design/fbhd_ram.sv
// ----------------------------------------------------------------------------
// fbhd_ram
// simple dual-port ram, one write and one read port, registered read data
// ----------------------------------------------------------------------------
module fbhd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: design/fbhd_queue.sv
// ----------------------------------------------------------------------------
// fbhd_queue
// short first-in first-out queue between the front and the back
// ----------------------------------------------------------------------------
module fbhd_queue #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 4,
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   input  logic              pop,
   output logic              full,
   output logic              head_valid,
   output logic [DATA_W-1:0] head_data
);

   logic [DATA_W-1:0] entries_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entries_ff[rd_ptr_ff];

endmodule

FILE: design/fbhd_front.sv
// ----------------------------------------------------------------------------
// fbhd_front
// takes input transactions, tracks raster position, applies the burn rule and
// tags each cell with the work the back has to do
// ----------------------------------------------------------------------------
module fbhd_front
   import fbhd_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   localparam int XW = $clog2(MAX_WIDTH),
   localparam int YW = $clog2(MAX_HEIGHT)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             restart,
   input  logic [CFG_W-1:0] frame_width,
   input  logic [CFG_W-1:0] frame_height,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   input  logic             queue_full,
   output logic             push,
   output cell_type         push_cell,
   output flags_type        push_flags,
   output logic [XW-1:0]    push_col,
   output logic [XW-1:0]    push_pend_addr,
   output logic [XW-1:0]    push_upper_addr
);

   localparam int WCMP_W = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
   localparam int HCMP_W = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;

   logic [XW-1:0]     col_ff, col_in, col_last;
   logic [YW-1:0]     row_ff, row_in, row_last;
   logic [WCMP_W-1:0] width_raw;
   logic [HCMP_W-1:0] height_raw;
   logic              at_col_last, at_row_last, inner;

   // clamp the geometry registers to the supported range
   always_comb begin
      width_raw = WCMP_W'(frame_width);
      if (width_raw < WCMP_W'(MIN_WIDTH)) begin
         col_last = XW'(MIN_WIDTH - 1);
      end else if (width_raw > WCMP_W'(MAX_WIDTH)) begin
         col_last = XW'(MAX_WIDTH - 1);
      end else begin
         col_last = XW'(width_raw - WCMP_W'(1));
      end
   end

   always_comb begin
      height_raw = HCMP_W'(frame_height);
      if (height_raw < HCMP_W'(MIN_HEIGHT)) begin
         row_last = YW'(MIN_HEIGHT - 1);
      end else if (height_raw > HCMP_W'(MAX_HEIGHT)) begin
         row_last = YW'(MAX_HEIGHT - 1);
      end else begin
         row_last = YW'(height_raw - HCMP_W'(1));
      end
   end

   assign at_col_last = (col_ff == col_last);
   assign at_row_last = (row_ff == row_last);
   assign inner       = (col_ff != '0) && !at_col_last;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (push) begin
         if (at_col_last) begin
            col_in = '0;
            row_in = at_row_last ? '0 : row_ff + YW'(1);
         end else begin
            col_in = col_ff + XW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign push_cell = burn_cell(req_data.cell_heat, req_data.cell_fuel, inner);
   assign push_col  = col_ff;

   // read-ahead addresses, wrapping around the row
   always_comb begin
      if (at_col_last) begin
         push_pend_addr = XW'(1);
      end else if (col_ff == col_last - XW'(1)) begin
         push_pend_addr = '0;
      end else begin
         push_pend_addr = col_ff + XW'(2);
      end
      push_upper_addr = at_col_last ? '0 : col_ff + XW'(1);
   end

   always_comb begin
      push_flags.emit_upper = (row_ff != '0);
      push_flags.diff_upper = (row_ff > YW'(1)) && inner;
      push_flags.emit_prev  = at_row_last && (col_ff != '0);
      push_flags.diff_prev  = at_row_last && (col_ff > XW'(1));
      push_flags.emit_last  = at_row_last && at_col_last;
   end

endmodule

FILE: design/fbhd_back.sv
// ----------------------------------------------------------------------------
// fbhd_back
// row buffers, diffusion and result sequencing into the output register
// ----------------------------------------------------------------------------
module fbhd_back
   import fbhd_pkg::*;
#(
   parameter int MAX_WIDTH = 1024,
   localparam int XW = $clog2(MAX_WIDTH)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          head_valid,
   input  cell_type      head_cell,
   input  flags_type     head_flags,
   input  logic [XW-1:0] head_col,
   input  logic [XW-1:0] head_pend_addr,
   input  logic [XW-1:0] head_upper_addr,
   output logic          pop,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_data
);

   localparam logic [1:0] PH_UPPER = 2'd0;
   localparam logic [1:0] PH_PREV  = 2'd1;
   localparam logic [1:0] PH_LAST  = 2'd2;

   localparam int CELL_W = $bits(cell_type);

   logic [1:0]        phase_ff, phase_in;
   cell_type          self_ff, self_in;
   cell_type          prev_cell_ff, prev_cell_in;
   logic [7:0]        prev_fin_ff, prev_fin_in;
   logic [7:0]        left_fin_ff, left_fin_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   logic [CELL_W-1:0] pend_rdata;
   cell_type          right_cell;
   logic [7:0]        upper_rdata;
   logic [7:0]        fin_upper, fin_prev;
   logic              has_out, last_step, out_free, advance;
   rsp_type           result;

   // pending row: burn values waiting for the row below
   fbhd_ram #(
      .WIDTH (CELL_W),
      .DEPTH (MAX_WIDTH)
   ) u_pend_ram (
      .clock (clock),
      .we    (pop),
      .waddr (head_col),
      .wdata (head_cell),
      .re    (pop),
      .raddr (head_pend_addr),
      .rdata (pend_rdata)
   );

   // final heat of the row above the pending row
   fbhd_ram #(
      .WIDTH (8),
      .DEPTH (MAX_WIDTH)
   ) u_upper_ram (
      .clock (clock),
      .we    (pop && head_flags.emit_upper),
      .waddr (head_col),
      .wdata (fin_upper),
      .re    (pop),
      .raddr (head_upper_addr),
      .rdata (upper_rdata)
   );

   assign right_cell = cell_type'(pend_rdata);

   always_comb begin
      fin_upper = head_flags.diff_upper
                ? diffuse(self_ff.heat, prev_fin_ff, right_cell.heat, upper_rdata,
                          head_cell.heat)
                : self_ff.heat;
      fin_prev  = head_flags.diff_prev
                ? diffuse(prev_cell_ff.heat, left_fin_ff, head_cell.heat, prev_fin_ff, 8'd0)
                : prev_cell_ff.heat;
   end

   always_comb begin
      has_out   = 1'b0;
      last_step = 1'b1;
      result    = '0;
      unique case (phase_ff)
         PH_UPPER: begin
            has_out         = head_flags.emit_upper;
            last_step       = !head_flags.emit_prev;
            result.new_heat = fin_upper;
            result.new_fuel = self_ff.fuel;
            result.burnt_out = self_ff.burnt;
         end
         PH_PREV: begin
            has_out         = 1'b1;
            last_step       = !head_flags.emit_last;
            result.new_heat = fin_prev;
            result.new_fuel = prev_cell_ff.fuel;
            result.burnt_out = prev_cell_ff.burnt;
         end
         PH_LAST: begin
            has_out         = 1'b1;
            last_step       = 1'b1;
            result.new_heat = head_cell.heat;
            result.new_fuel = head_cell.fuel;
            result.burnt_out = head_cell.burnt;
         end
         default: begin
            has_out   = 1'b0;
            last_step = 1'b1;
         end
      endcase
      result.last_of_run = last_step;
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign advance  = head_valid && (out_free || !has_out);
   assign pop      = advance && last_step;

   always_comb begin
      phase_in     = phase_ff;
      self_in      = self_ff;
      prev_cell_in = prev_cell_ff;
      prev_fin_in  = prev_fin_ff;
      left_fin_in  = left_fin_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         phase_in = last_step ? PH_UPPER : phase_ff + 2'd1;
         if (phase_ff == PH_PREV) begin
            left_fin_in = fin_prev;
         end
      end
      if (pop) begin
         self_in      = right_cell;
         prev_cell_in = head_cell;
         prev_fin_in  = fin_upper;
      end
      if (out_free) begin
         rsp_valid_in = advance && has_out;
         rsp_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_UPPER;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      self_ff      <= self_in;
      prev_cell_ff <= prev_cell_in;
      prev_fin_ff  <= prev_fin_in;
      left_fin_ff  <= left_fin_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the fire burn and heat diffusion block. Cells are
// streamed in raster order over frames of many sizes, clamped ones included,
// and every emitted cell is compared field by field with a cycle-free
// prediction of the burn and diffusion rules kept in this file.
// ----------------------------------------------------------------------------
module tb
   import fbhd_pkg::*;
;

   localparam int MAX_W          = 1024;
   localparam int MAX_H          = 1024;
   localparam int SETTLE_CYCLES  = 16;    // generous cover for the front queue
   localparam int LONG_HOLD      = 300;   // one long receiver hold-off
   localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transaction at all
   localparam int RANDOM_CELLS   = 150;
   localparam int WIDE_CELLS     = 24;    // first part of the top row of the widest frame
   localparam int TALL_CELLS     = 60;    // first twenty rows of the tallest frame

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   // -------------------------------------------------------------------------
   // frame tracker: predicts the emitted cells and checks what comes out
   // -------------------------------------------------------------------------
   class heat_frame_tracker;
      logic [CFG_W-1:0] width_reg;
      logic [CFG_W-1:0] height_reg;
      logic [7:0]       held_heat [MAX_W];   // burn values of the waiting row
      logic [7:0]       held_fuel [MAX_W];
      logic             held_burnt [MAX_W];
      logic [7:0]       above_heat [MAX_W];  // final heat of the row above
      logic [7:0]       prior_heat;          // final heat left of us, last row
      int               col;
      int               line;
      rsp_type          due_cells [$];
      int               mismatches;

      function new();
         width_reg  = RESET_FRAME_WIDTH;
         height_reg = RESET_FRAME_HEIGHT;
         foreach (held_heat[i]) begin
            held_heat[i]  = '0;
            held_fuel[i]  = '0;
            held_burnt[i] = 1'b0;
            above_heat[i] = '0;
         end
         prior_heat = '0;
         col        = 0;
         line       = 0;
         mismatches = 0;
      endfunction

      function void write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
         if (idx == REG_FRAME_WIDTH) begin
            width_reg = value;
         end else begin
            height_reg = value;
         end
         // any write restarts the frame, stored rows stay
         col        = 0;
         line       = 0;
         prior_heat = '0;
      endfunction

      function automatic logic [7:0] spread_heat(logic [7:0] self_h, logic [7:0] left_h,
                                                 logic [7:0] right_h, logic [7:0] up_h,
                                                 logic [7:0] down_h);
         int q;
         q = (int'(self_h) + int'(left_h) + int'(right_h) + 2 * int'(up_h)
              + 6 * int'(down_h)) / 11;
         if (q < int'(self_h)) q = int'(self_h);
         return q[7:0];
      endfunction

      function automatic rsp_type make_cell(logic [7:0] heat, logic [7:0] fuel, logic burnt);
         rsp_type r;
         r.new_heat    = heat;
         r.new_fuel    = fuel;
         r.burnt_out   = burnt;
         r.last_of_run = 1'b0;
         return r;
      endfunction

      function void take_cell(req_type item);
         rsp_type    outs [3];
         int         w, h, x, y, n;
         logic [7:0] heat, fuel, loss, fin;
         logic       burnt;
         w = int'(width_reg);
         if (w < MIN_WIDTH) w = MIN_WIDTH;
         if (w > MAX_W) w = MAX_W;
         h = int'(height_reg);
         if (h < MIN_HEIGHT) h = MIN_HEIGHT;
         if (h > MAX_H) h = MAX_H;
         x = (col >= w) ? w - 1 : col;
         y = (line >= h) ? h - 1 : line;
         heat  = item.cell_heat;
         fuel  = item.cell_fuel;
         burnt = 1'b0;
         n     = 0;

         // burn rule, inner columns only
         if (x >= 1 && x + 1 < w) begin
            if (fuel != 8'd0) begin
               if (heat > 8'd50) begin
                  loss = (heat > 8'd200) ? 8'd4 : ((heat > 8'd100) ? 8'd2 : 8'd1);
                  if (fuel <= loss) begin
                     heat  = 8'd0;
                     fuel  = 8'd0;
                     burnt = 1'b1;
                  end else begin
                     fuel = fuel - loss;
                     if (heat < 8'd250) heat = heat + 8'd2;
                  end
               end
            end else if (heat != 8'd0) begin
               heat = heat - 8'd1;
            end
         end

         // the cell one row up is now complete
         if (y >= 1) begin
            fin = held_heat[x];
            if (y >= 2 && x >= 1 && x + 1 < w)
               fin = spread_heat(held_heat[x], above_heat[x - 1], held_heat[x + 1],
                                 above_heat[x], heat);
            above_heat[x] = fin;
            outs[n] = make_cell(fin, held_fuel[x], held_burnt[x]);
            n++;
         end

         held_heat[x]  = heat;
         held_fuel[x]  = fuel;
         held_burnt[x] = burnt;

         // last row: nothing below, flush left neighbor and the final cell
         if (y == h - 1) begin
            if (x >= 1) begin
               fin = held_heat[x - 1];
               if (x >= 2)
                  fin = spread_heat(held_heat[x - 1], prior_heat, held_heat[x],
                                    above_heat[x - 1], 8'd0);
               prior_heat = fin;
               outs[n] = make_cell(fin, held_fuel[x - 1], held_burnt[x - 1]);
               n++;
            end
            if (x == w - 1) begin
               outs[n] = make_cell(held_heat[x], held_fuel[x], held_burnt[x]);
               n++;
            end
         end

         if (n > 0) outs[n - 1].last_of_run = 1'b1;
         for (int k = 0; k < n; k++) due_cells.push_back(outs[k]);

         // raster position
         if (x + 1 >= w) begin
            col = 0;
            if (y + 1 >= h) begin
               line       = 0;
               prior_heat = '0;
            end else begin
               line = y + 1;
            end
         end else begin
            col  = x + 1;
            line = y;
         end
      endfunction

      function void match_result(rsp_type got);
         rsp_type want;
         if (due_cells.size() == 0) begin
            $error("unexpected result: heat %0d fuel %0d burnt %0d last %0d",
                   got.new_heat, got.new_fuel, got.burnt_out, got.last_of_run);
            mismatches++;
            return;
         end
         want = due_cells.pop_front();
         if (got.new_heat !== want.new_heat) begin
            $error("new_heat: expected %0d, actual %0d", want.new_heat, got.new_heat);
            mismatches++;
         end
         if (got.new_fuel !== want.new_fuel) begin
            $error("new_fuel: expected %0d, actual %0d", want.new_fuel, got.new_fuel);
            mismatches++;
         end
         if (got.burnt_out !== want.burnt_out) begin
            $error("burnt_out: expected %0d, actual %0d", want.burnt_out, got.burnt_out);
            mismatches++;
         end
         if (got.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0d, actual %0d", want.last_of_run,
                   got.last_of_run);
            mismatches++;
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // block and its signals
   // -------------------------------------------------------------------------
   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   req_type            req_data;
   logic               rsp_valid;
   logic               rsp_stall;
   rsp_type            rsp_data;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [PADDR_W-1:0] paddr;
   logic [PDATA_W-1:0] pwdata;
   logic [PDATA_W-1:0] prdata;
   logic               pready;

   fire_burn_and_heat_diffusion #(
      .MAX_WIDTH  (MAX_W),
      .MAX_HEIGHT (MAX_H)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   heat_frame_tracker tracker;
   int                burst_left = 0;   // cells left in the current sender burst
   logic              hold_req   = 1'b0; // raised by the stimulus, seen by the receiver
   logic              hold_done  = 1'b0; // set by the receiver once the hold is over
   int                idle_cycles = 0;
   logic [15:0]       opening_cells [22];

   // 12 ns clock
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // -------------------------------------------------------------------------
   // result side: stall pattern of its own plus one long hold-off
   // -------------------------------------------------------------------------
   initial begin
      stall_mode_type mode;
      int             span;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_req && !hold_done) begin
            // hold the output long enough for the input to back up
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
            hold_done = 1'b1;
         end
         mode = stall_mode_type'($urandom_range(0, 3));
         span = $urandom_range(10, 120);
         for (int k = 0; k < span; k++) begin
            // a pending hold-off request cuts the pattern short
            if (hold_req && !hold_done) break;
            case (mode)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 99) < 30);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 99) < 75);
               default:     rsp_stall <= (k % 4 != 0);
            endcase
            @(negedge clock);
         end
      end
   end

   // every accepted result goes straight to the checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         tracker.match_result(rsp_data);
      end
   end

   // watchdog: a long stretch with no transaction on either channel is a hang
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // -------------------------------------------------------------------------
   // configuration port
   // -------------------------------------------------------------------------
   task automatic csr_read(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== PDATA_W'(value)) begin
         $error("register %0d readback: expected %0d, actual %0d", idx, value, prdata);
         tracker.mismatches++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic csr_write(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      // junk above the register width must be dropped
      pwdata  <= {(PDATA_W - CFG_W)'($urandom), value};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      tracker.write_reg(idx, value);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      csr_read(idx, value);
   endtask

   task automatic set_geometry(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
      csr_write(REG_FRAME_WIDTH, w);
      csr_write(REG_FRAME_HEIGHT, h);
   endtask

   // -------------------------------------------------------------------------
   // input side
   // -------------------------------------------------------------------------
   // drop valid, wait for every expected cell, then give the block some slack
   task automatic drain(input int slack);
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.due_cells.size() != 0) @(posedge clock);
      repeat (slack) @(posedge clock);
   endtask

   // one transaction, sent in bursts with random gaps between them
   task automatic offer_cell(input req_type item);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      tracker.take_cell(item);
   endtask

   // mostly uniform cells, some sitting on the burn thresholds or without fuel
   function automatic req_type pick_cell();
      req_type c;
      int      kind;
      int      edges [15] = '{0, 1, 49, 50, 51, 52, 100, 101, 200, 201, 248, 249, 250,
                              251, 255};
      kind        = $urandom_range(0, 5);
      c.cell_heat = 8'($urandom);
      c.cell_fuel = 8'($urandom);
      if (kind == 4) begin
         c.cell_heat = 8'(edges[$urandom_range(0, 14)]);
         c.cell_fuel = 8'($urandom_range(0, 5));
      end else if (kind == 5) begin
         c.cell_fuel = 8'd0;
      end
      return c;
   endfunction

   task automatic stream_cells(input int count);
      for (int i = 0; i < count; i++) offer_cell(pick_cell());
   endtask

   // -------------------------------------------------------------------------
   // stimulus
   // -------------------------------------------------------------------------
   initial begin
      int               random_cells;
      int               ew, eh, cells;
      logic [CFG_W-1:0] w, h;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      psel      = 1'b0;
      penable   = 1'b0;
      pwrite    = 1'b0;
      paddr     = '0;
      pwdata    = '0;
      tracker   = new();

      // heat/fuel pairs, five per row
      opening_cells = '{
         // first row: burn out at top rate, one fuel left, no gain at the cap
         16'hFFFF, 16'hC904, 16'hC905, 16'hFA09, 16'h0000,
         // lowest rate burn out, just below ignition, cooling of unfueled cells
         16'h1020, 16'h3301, 16'h3207, 16'hFF00, 16'h0100,
         // last row: diffusion with nothing below
         16'h8080, 16'h6503, 16'hC802, 16'h64C8, 16'h0C22,
         // partial frame, cut short by a register write
         16'h7FFF, 16'h00FF, 16'h0000, 16'hFB05, 16'h3300,
         16'h5A5A, 16'h0001
      };

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // registers come out of reset at full size
      csr_read(REG_FRAME_WIDTH, RESET_FRAME_WIDTH);
      csr_read(REG_FRAME_HEIGHT, RESET_FRAME_HEIGHT);

      // directed frame of 5 x 3, then seven more cells cut off mid-frame
      set_geometry(11'd5, 11'd3);
      foreach (opening_cells[i]) begin
         offer_cell(req_type'(opening_cells[i]));
         // sender pauses mid-frame until the output is empty
         if (i == 7) drain(0);
      end
      drain(SETTLE_CYCLES);

      // random frames, mostly small, now and then a clamped size
      random_cells = 0;
      while (random_cells < RANDOM_CELLS) begin
         w = ($urandom_range(0, 9) == 0) ? CFG_W'($urandom_range(0, 3))
                                         : CFG_W'($urandom_range(3, 12));
         h = ($urandom_range(0, 9) == 0) ? CFG_W'($urandom_range(0, 2))
                                         : CFG_W'($urandom_range(2, 6));
         set_geometry(w, h);
         ew    = (w < MIN_WIDTH) ? MIN_WIDTH : int'(w);
         eh    = (h < MIN_HEIGHT) ? MIN_HEIGHT : int'(h);
         cells = $urandom_range(1, 3) * ew * eh;
         // sometimes leave the frame unfinished so the next write restarts it
         if ($urandom_range(0, 3) == 0) cells += $urandom_range(1, ew * eh - 1);
         if (cells > RANDOM_CELLS - random_cells) cells = RANDOM_CELLS - random_cells;
         stream_cells(cells);
         random_cells += cells;
         drain(SETTLE_CYCLES);
      end

      // widest frame (clamped from the top code), start of its first row only
      set_geometry(11'd2047, 11'd2);
      stream_cells(WIDE_CELLS);
      drain(SETTLE_CYCLES);

      // tallest frame, narrowest clamped width; the receiver holds off once here
      set_geometry(11'd0, 11'd2047);
      hold_req = 1'b1;
      stream_cells(TALL_CELLS);
      drain(SETTLE_CYCLES);

      if (tracker.mismatches == 0 && tracker.due_cells.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
